// ===== design/vadpcm_pkg.sv =====
// vadpcm_pkg: shared types, constants, the step-size table and the index-move
// function for the variable-rate adpcm decoder; no dependencies
`default_nettype none

package vadpcm_pkg;

  // sequencer states
  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } vad_state_e;

  localparam int unsigned PRED_W = 12;
  localparam int unsigned STEP_W = 14;
  localparam int unsigned IDX_W  = 7;

  localparam logic [IDX_W-1:0] RESET_STEP       = 7'd40;
  localparam logic [IDX_W-1:0] SMALL_STEP_LIMIT = 7'd18;
  localparam logic [IDX_W-1:0] STEP_MAX         = 7'd79;

  localparam logic signed [PRED_W-1:0] PRED_MIN = -12'sd2048;
  localparam logic signed [PRED_W-1:0] PRED_MAX = 12'sd2047;

  // ima step-size table, 80 entries
  function automatic logic [STEP_W-1:0] vad_step_size(input logic [IDX_W-1:0] idx);
    logic [STEP_W-1:0] s;
    case (idx)
      7'd0:  s = 14'd7;     7'd1:  s = 14'd8;     7'd2:  s = 14'd9;     7'd3:  s = 14'd10;
      7'd4:  s = 14'd11;    7'd5:  s = 14'd12;    7'd6:  s = 14'd13;    7'd7:  s = 14'd14;
      7'd8:  s = 14'd16;    7'd9:  s = 14'd17;    7'd10: s = 14'd19;    7'd11: s = 14'd21;
      7'd12: s = 14'd23;    7'd13: s = 14'd25;    7'd14: s = 14'd28;    7'd15: s = 14'd31;
      7'd16: s = 14'd34;    7'd17: s = 14'd37;    7'd18: s = 14'd41;    7'd19: s = 14'd45;
      7'd20: s = 14'd50;    7'd21: s = 14'd55;    7'd22: s = 14'd60;    7'd23: s = 14'd66;
      7'd24: s = 14'd73;    7'd25: s = 14'd80;    7'd26: s = 14'd88;    7'd27: s = 14'd97;
      7'd28: s = 14'd107;   7'd29: s = 14'd118;   7'd30: s = 14'd130;   7'd31: s = 14'd143;
      7'd32: s = 14'd157;   7'd33: s = 14'd173;   7'd34: s = 14'd190;   7'd35: s = 14'd209;
      7'd36: s = 14'd230;   7'd37: s = 14'd253;   7'd38: s = 14'd279;   7'd39: s = 14'd307;
      7'd40: s = 14'd337;   7'd41: s = 14'd371;   7'd42: s = 14'd408;   7'd43: s = 14'd449;
      7'd44: s = 14'd494;   7'd45: s = 14'd544;   7'd46: s = 14'd598;   7'd47: s = 14'd658;
      7'd48: s = 14'd724;   7'd49: s = 14'd796;   7'd50: s = 14'd876;   7'd51: s = 14'd963;
      7'd52: s = 14'd1060;  7'd53: s = 14'd1166;  7'd54: s = 14'd1282;  7'd55: s = 14'd1411;
      7'd56: s = 14'd1552;  7'd57: s = 14'd1707;  7'd58: s = 14'd1878;  7'd59: s = 14'd2066;
      7'd60: s = 14'd2272;  7'd61: s = 14'd2499;  7'd62: s = 14'd2749;  7'd63: s = 14'd3024;
      7'd64: s = 14'd3327;  7'd65: s = 14'd3660;  7'd66: s = 14'd4026;  7'd67: s = 14'd4428;
      7'd68: s = 14'd4871;  7'd69: s = 14'd5358;  7'd70: s = 14'd5894;  7'd71: s = 14'd6484;
      7'd72: s = 14'd7132;  7'd73: s = 14'd7845;  7'd74: s = 14'd8630;  7'd75: s = 14'd9493;
      7'd76: s = 14'd10442; 7'd77: s = 14'd11487; 7'd78: s = 14'd12635;
      default: s = 14'd13899;
    endcase
    return s;
  endfunction

  // index move for a 4-bit code, by its magnitude bits
  function automatic logic signed [4:0] vad_move_four(input logic [2:0] mag);
    logic signed [4:0] m;
    case (mag)
      3'd4:    m = 5'sd2;
      3'd5:    m = 5'sd4;
      3'd6:    m = 5'sd6;
      3'd7:    m = 5'sd8;
      default: m = -5'sd1;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

// ===== design/vadpcm_in_if.sv =====
// vadpcm_in_if: valid/ready channel carrying one packed code byte
// no dependencies
`default_nettype none

interface vadpcm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;
  logic       track_end;

  modport source (output valid, output code_byte, output track_end, input ready);
  modport sink   (input valid, input code_byte, input track_end, output ready);
endinterface

`default_nettype wire

// ===== design/vadpcm_out_if.sv =====
// vadpcm_out_if: valid/ready channel carrying one decoded pcm sample
// no dependencies
`default_nettype none

interface vadpcm_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pcm_sample;
  logic               last_of_byte;
  logic               last_of_track;

  modport source (output valid, output pcm_sample, output last_of_byte,
                  output last_of_track, input ready);
  modport sink   (input valid, input pcm_sample, input last_of_byte,
                  input last_of_track, output ready);
endinterface

`default_nettype wire

// ===== design/variable_ima_adpcm_decoder.sv =====
// variable_ima_adpcm_decoder: top level, byte sequencer and shared code unit
// depends on vadpcm_pkg, vadpcm_in_if, vadpcm_out_if
//
//   channel | dir | payload                                    | transaction
//   code_i  | in  | code_byte[7:0], track_end                  | valid & ready
//   pcm_o   | out | pcm_sample[15:0], last_of_byte, last_of_track | valid & ready
//
// a byte is taken while idle, then decoded one code per cycle, 2 to 4
// codes, when the output keeps up; a new byte is taken only after its last code
// the single code unit (step table, difference adder, clamps) sets that rate
// code_i is ready only while no byte is being decoded
// a stalled output register holds the code unit; nothing is lost or repeated
// rst_ni clears predictor to 0 and step index to 40, no clearing pass
`default_nettype none

module variable_ima_adpcm_decoder
  import vadpcm_pkg::*;
(
  input  wire             clk_i,
  input  wire             rst_ni,
  vadpcm_in_if.sink       code_i,
  vadpcm_out_if.source    pcm_o
);

  vad_state_e state_q, state_d;

  logic signed [PRED_W-1:0] pred_q, pred_d;
  logic [IDX_W-1:0]         idx_q, idx_d;
  logic [1:0]               pos_q, pos_d;
  logic [7:0]               bits_q, bits_d;
  logic                     end_q, end_d;

  logic                     out_valid_q, out_valid_d;
  logic signed [15:0]       out_sample_q, out_sample_d;
  logic                     out_lob_q, out_lob_d;
  logic                     out_lot_q, out_lot_d;

  logic in_ready;
  logic step_en;

  // shared code unit signals
  logic [STEP_W-1:0]        step_sz;
  logic                     small_code;
  logic [15:0]              mag;
  logic                     neg;
  logic signed [4:0]        move;
  logic signed [16:0]       sum;
  logic signed [PRED_W-1:0] pred_new;
  logic signed [7:0]        idx_sum;
  logic [IDX_W-1:0]         idx_new;
  logic [2:0]               pos_next;
  logic                     last_code;

  // code unit: one code per cycle while the output register is not stalled
  always_comb begin
    step_sz    = vad_step_size(idx_q);
    small_code = (idx_q < SMALL_STEP_LIMIT) || (pos_q == 2'd3);
    mag        = {5'b0, step_sz[STEP_W-1:3]};
    if (small_code) begin
      if (bits_q[0]) mag = mag + {2'b0, step_sz};
      neg  = bits_q[1];
      move = bits_q[0] ? 5'sd2 : -5'sd1;
    end else begin
      if (bits_q[0]) mag = mag + {4'b0, step_sz[STEP_W-1:2]};
      if (bits_q[1]) mag = mag + {3'b0, step_sz[STEP_W-1:1]};
      if (bits_q[2]) mag = mag + {2'b0, step_sz};
      neg  = bits_q[3];
      move = vad_move_four(bits_q[2:0]);
    end
    sum = {{5{pred_q[PRED_W-1]}}, pred_q}
        + (neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag}));
    if (sum < $signed({{5{PRED_MIN[PRED_W-1]}}, PRED_MIN})) begin
      pred_new = PRED_MIN;
    end else if (sum > $signed({5'b0, PRED_MAX})) begin
      pred_new = PRED_MAX;
    end else begin
      pred_new = sum[PRED_W-1:0];
    end
    idx_sum = $signed({1'b0, idx_q}) + {{3{move[4]}}, move};
    if (idx_sum < 8'sd0) begin
      idx_new = '0;
    end else if (idx_sum > $signed({1'b0, STEP_MAX})) begin
      idx_new = STEP_MAX;
    end else begin
      idx_new = idx_sum[IDX_W-1:0];
    end
    pos_next  = {1'b0, pos_q} + (small_code ? 3'd1 : 3'd2);
    last_code = pos_next[2];
  end

  // sequencer state, output valid, predictor, step index and code position registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      pred_q      <= '0;
      idx_q       <= RESET_STEP;
      pos_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      pred_q      <= pred_d;
      idx_q       <= idx_d;
      pos_q       <= pos_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    bits_q       <= bits_d;
    end_q        <= end_d;
    out_sample_q <= out_sample_d;
    out_lob_q    <= out_lob_d;
    out_lot_q    <= out_lot_d;
  end

  // next state and datapath control
  always_comb begin
    state_d      = state_q;
    in_ready     = 1'b0;
    step_en      = 1'b0;
    pred_d       = pred_q;
    idx_d        = idx_q;
    pos_d        = pos_q;
    bits_d       = bits_q;
    end_d        = end_q;
    out_sample_d = out_sample_q;
    out_lob_d    = out_lob_q;
    out_lot_d    = out_lot_q;
    out_valid_d  = out_valid_q && !pcm_o.ready;
    case (state_q)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (code_i.valid) begin
          bits_d  = code_i.code_byte;
          end_d   = code_i.track_end;
          pos_d   = '0;
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        step_en = !out_valid_q || pcm_o.ready;
        if (step_en) begin
          out_valid_d  = 1'b1;
          out_sample_d = {pred_new, 4'b0};
          out_lob_d    = last_code;
          out_lot_d    = last_code && end_q;
          bits_d       = small_code ? {2'b0, bits_q[7:2]} : {4'b0, bits_q[7:4]};
          pos_d        = pos_next[1:0];
          if (last_code && end_q) begin
            pred_d = '0;
            idx_d  = RESET_STEP;
          end else begin
            pred_d = pred_new;
            idx_d  = idx_new;
          end
          if (last_code) state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign code_i.ready        = in_ready;
  assign pcm_o.valid         = out_valid_q;
  assign pcm_o.pcm_sample    = out_sample_q;
  assign pcm_o.last_of_byte  = out_lob_q;
  assign pcm_o.last_of_track = out_lot_q;

`ifndef SYNTHESIS
  // step index stays inside the table
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= STEP_MAX)
    else $error("step index out of range");

  // end of track restores the start state
  a_track_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_en && last_code && end_q) |=> (pred_q == '0 && idx_q == RESET_STEP))
    else $error("state not restored after end of track");

  // an accepted byte starts decoding at its first code
  a_byte_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (code_i.valid && code_i.ready) |=> (state_q == ST_RUN && pos_q == 2'd0))
    else $error("byte did not start at first code");

  // end of track is only flagged on the final sample of a byte
  a_lot_lob: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_lot_q) |-> out_lob_q)
    else $error("last_of_track without last_of_byte");

  // no code is computed while a byte is being taken
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_en |-> !in_ready)
    else $error("code step while accepting a byte");
`endif

endmodule

`default_nettype wire
